// File: hdl/picc_pkg.sv
// ----------------------------------------------------------------------------
// picc_pkg
// Shared widths, request codes and control types for the interrupt claim /
// complete controller.
// ----------------------------------------------------------------------------
package picc_pkg;

  // default geometry
  localparam int unsigned NumSourcesDef   = 32;
  localparam int unsigned PriorityBitsDef = 3;

  // fixed field widths
  localparam int unsigned SrcW      = 5;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned ThreshW   = 3;
  localparam int unsigned SlotBits  = 3;
  localparam int unsigned PrioRegW  = 48;
  localparam int unsigned EnableW   = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 48;

  // request codes
  localparam logic [ReqW-1:0] REQ_RAISE    = 2'd0;
  localparam logic [ReqW-1:0] REQ_CLAIM    = 2'd1;
  localparam logic [ReqW-1:0] REQ_COMPLETE = 2'd2;
  localparam logic [ReqW-1:0] REQ_QUERY    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_LOW   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRIO_HIGH  = 2'd3;

  // sequencer to arbiter control
  typedef struct packed {
    logic start;  // load threshold, clear best id
    logic step;   // present one candidate source
  } arb_ctrl_t;

endpackage

// File: hdl/picc_arb.sv
// ----------------------------------------------------------------------------
// picc_arb
// Shared priority compare unit: sees one candidate source per cycle on step
// and keeps the best priority and id seen so far. Ties keep the earlier (lower) id.
// ----------------------------------------------------------------------------
module picc_arb
  import picc_pkg::*;
#(
  parameter int unsigned IdxW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arb_ctrl_t          ctrl_i,
  input  logic [ThreshW-1:0] threshold_i,
  input  logic               cand_valid_i,
  input  logic [IdxW-1:0]    cand_id_i,
  input  logic [ThreshW-1:0] cand_prio_i,
  output logic [IdxW-1:0]    best_id_o
);

  logic [ThreshW-1:0] best_prio_q, best_prio_d;
  logic [IdxW-1:0]    best_id_q, best_id_d;
  logic               win;

  // strictly greater wins, so ties stay with the lower id
  assign win = ctrl_i.step && cand_valid_i && (cand_prio_i > best_prio_q);

  always_comb begin
    best_prio_d = best_prio_q;
    best_id_d   = best_id_q;
    if (ctrl_i.start) begin
      best_prio_d = threshold_i;
      best_id_d   = '0;
    end else if (win) begin
      best_prio_d = cand_prio_i;
      best_id_d   = cand_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_prio_q <= '0;
      best_id_q   <= '0;
    end else begin
      best_prio_q <= best_prio_d;
      best_id_q   <= best_id_d;
    end
  end

  assign best_id_o = best_id_q;

  // a winner always beats the threshold it was loaded with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win |=> (best_prio_q > $past(best_prio_q)))
    else $error("picc_arb: winner did not raise best priority");

  // start always clears the grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> (best_id_q == '0))
    else $error("picc_arb: best id not cleared on start");

  // a nonzero grant never carries a zero priority
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_id_q != '0) |-> (best_prio_q != '0))
    else $error("picc_arb: grant with zero priority");

endmodule

// File: hdl/interrupt_claim_complete_controller_top.sv
// ----------------------------------------------------------------------------
// interrupt_claim_complete_controller_top
// Single-context platform interrupt controller with claim / complete flow.
// ----------------------------------------------------------------------------
// Raise, completion and pending query words are taken in the idle state and
// their result goes straight to the output register when it is free, so they
// can follow each other every cycle. A claim scans sources 1 to NUM_SOURCES-1
// one per cycle through a single shared priority comparator, then updates
// pending / in-service bits in S_COMMIT and hands the result to the output
// register in S_EMIT before the next request is accepted. in_ready_o is low
// while a claim is scanning or committing, or while a result waits for the
// output register.
module interrupt_claim_complete_controller_top
  import picc_pkg::*;
#(
  parameter int unsigned NUM_SOURCES   = NumSourcesDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [SrcW-1:0]     source_id_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SrcW-1:0]     claimed_id_o,
  output logic                is_pending_o
);

  localparam int unsigned IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SOURCES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  // configuration registers
  logic [ThreshW-1:0]     threshold_q;
  logic [NUM_SOURCES-1:0] enable_q;
  logic [PrioRegW-1:0]    prio_low_q, prio_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      enable_q    <= '0;
      prio_low_q  <= '0;
      prio_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i[ThreshW-1:0];
        CFG_ENABLE:    enable_q    <= cfg_data_i[NUM_SOURCES-1:0];
        CFG_PRIO_LOW:  prio_low_q  <= cfg_data_i[PrioRegW-1:0];
        CFG_PRIO_HIGH: prio_high_q <= cfg_data_i[PrioRegW-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0]              state_q, state_d;
  logic [IdxW-1:0]         scan_idx_q, scan_idx_d;
  logic [NUM_SOURCES-1:0]  pending_q, pending_d;
  logic [NUM_SOURCES-1:0]  in_service_q, in_service_d;
  logic [SrcW-1:0]         res_claimed_q, res_claimed_d;
  logic                    res_pend_q, res_pend_d;
  logic                    out_valid_q, out_valid_d;
  logic [SrcW-1:0]         out_claimed_q, out_claimed_d;
  logic                    out_pend_q, out_pend_d;

  logic                    in_fire, out_free, src_ok;
  logic [IdxW-1:0]         src_idx;
  logic [2*PrioRegW-1:0]   prio_all;
  logic [PRIORITY_BITS-1:0] cand_prio_raw;
  logic [ThreshW-1:0]      cand_prio;
  logic                    cand_valid;
  logic [IdxW-1:0]         best_id;
  arb_ctrl_t               arb_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // source id decode: zero and ids beyond the source count are ignored
  assign src_ok  = (source_id_i != '0) && ({1'b0, source_id_i} < 6'(NUM_SOURCES));
  assign src_idx = source_id_i[IdxW-1:0];

  // priority of the source under scan
  assign prio_all      = {prio_high_q, prio_low_q};
  assign cand_prio_raw = prio_all[SlotBits*int'(scan_idx_q) +: PRIORITY_BITS];
  assign cand_prio     = ThreshW'(cand_prio_raw);
  assign cand_valid    = pending_q[scan_idx_q] && enable_q[scan_idx_q];

  assign arb_ctrl.start = in_fire && (req_type_i == REQ_CLAIM);
  assign arb_ctrl.step  = (state_q == S_SCAN);

  picc_arb #(
    .IdxW (IdxW)
  ) u_arb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (arb_ctrl),
    .threshold_i  (threshold_q),
    .cand_valid_i (cand_valid),
    .cand_id_i    (scan_idx_q),
    .cand_prio_i  (cand_prio),
    .best_id_o    (best_id)
  );

  // sequencer, interrupt state and result staging
  always_comb begin
    state_d       = state_q;
    scan_idx_d    = scan_idx_q;
    pending_d     = pending_q;
    in_service_d  = in_service_q;
    res_claimed_d = res_claimed_q;
    res_pend_d    = res_pend_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_claimed_d = out_claimed_q;
    out_pend_d    = out_pend_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_claimed_d = '0;
          res_pend_d    = 1'b0;
          case (req_type_i)
            REQ_RAISE: begin
              if (src_ok && !in_service_q[src_idx]) pending_d[src_idx] = 1'b1;
            end
            REQ_COMPLETE: begin
              if (src_ok && enable_q[src_idx]) in_service_d[src_idx] = 1'b0;
            end
            REQ_QUERY: begin
              res_pend_d = src_ok && pending_q[src_idx];
            end
            default: ;
          endcase
          if (req_type_i == REQ_CLAIM) begin
            scan_idx_d = IdxW'(1);
            state_d    = S_SCAN;
          end else if (out_free) begin
            out_valid_d   = 1'b1;
            out_claimed_d = '0;
            out_pend_d    = res_pend_d;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_q == LastIdx) begin
          state_d = S_COMMIT;
        end else begin
          scan_idx_d = scan_idx_q + IdxW'(1);
        end
      end
      S_COMMIT: begin
        if (best_id != '0) begin
          pending_d[best_id]    = 1'b0;
          in_service_d[best_id] = 1'b1;
        end
        res_claimed_d = SrcW'(best_id);
        res_pend_d    = 1'b0;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_claimed_d = res_claimed_q;
          out_pend_d    = res_pend_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_idx_q   <= '0;
      pending_q    <= '0;
      in_service_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_idx_q   <= scan_idx_d;
      pending_q    <= pending_d;
      in_service_q <= in_service_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_claimed_q <= res_claimed_d;
    res_pend_q    <= res_pend_d;
    out_claimed_q <= out_claimed_d;
    out_pend_q    <= out_pend_d;
  end

  assign out_valid_o  = out_valid_q;
  assign claimed_id_o = out_claimed_q;
  assign is_pending_o = out_pend_q;

  // a source is never pending and in service at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & in_service_q) == '0)
    else $error("picc: source both pending and in service");

  // source zero never takes part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q[0] && !in_service_q[0])
    else $error("picc: source zero became active");

  // the grant at commit is an enabled pending source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) && (best_id != '0) |->
      pending_q[best_id] && enable_q[best_id])
    else $error("picc: grant of a source that is not enabled and pending");

  // a claim word never reports a pending bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (claimed_id_o != '0) |-> !is_pending_o)
    else $error("picc: claim word with pending flag");

endmodule

// File: verif/interrupt_claim_complete_controller_top_tb.sv
// ----------------------------------------------------------------------------
// interrupt_claim_complete_controller_top_tb
// Self-checking bench for the claim / complete interrupt controller. A short
// directed script covers raises, claims, completions and pending queries
// around reset, threshold and enable corners. Random traffic follows in four
// flow-control phases. Every result word is checked in order against the row's
// typed answer or a cycle-free model of pending, in-service and arbitration state.
// ----------------------------------------------------------------------------
module interrupt_claim_complete_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import picc_pkg::*;

  localparam int unsigned NumSrc        = NumSourcesDef;
  localparam int unsigned MaxCycles     = 400000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned WordsPerPhase = 120;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [SrcW-1:0] NoGrant   = '0;

  typedef struct packed {
    logic [SrcW-1:0] claimed_id;
    logic            is_pending;
  } answer_t;

  typedef struct {
    bit                  is_cfg;
    logic [ReqW-1:0]     req;
    logic [SrcW-1:0]     src;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    bit                  typed;
    answer_t             want;
  } script_row_t;

  // dut ports, all driven to known values from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ReqW-1:0]     req_type_i  = REQ_RAISE;
  logic [SrcW-1:0]     source_id_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SrcW-1:0]     claimed_id_o;
  logic                is_pending_o;

  // controller model state
  logic [ThreshW-1:0]  mdl_threshold;
  logic [EnableW-1:0]  mdl_enable;
  logic [PrioRegW-1:0] mdl_prio_lo;
  logic [PrioRegW-1:0] mdl_prio_hi;
  logic [NumSrc-1:0]   mdl_pending;
  logic [NumSrc-1:0]   mdl_in_service;

  answer_t     answers_due[$];
  answer_t     want_now;
  script_row_t script[$];

  int unsigned cycle_count   = 0;
  int unsigned n_errors      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_words       = 0;
  int unsigned n_grants      = 0;
  int unsigned n_empty_claim = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  int unsigned rx_pct_now    = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  interrupt_claim_complete_controller_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .source_id_i  (source_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .claimed_id_o (claimed_id_o),
    .is_pending_o (is_pending_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // priority slot of one source
  function automatic logic [SlotBits-1:0] source_priority(int unsigned src);
    logic [PrioRegW-1:0] word;
    word = (src < 16) ? mdl_prio_lo : mdl_prio_hi;
    word = word >> ((src % 16) * SlotBits);
    return word[SlotBits-1:0] & SlotBits'((1 << PriorityBitsDef) - 1);
  endfunction

  // apply one request to the model and return its answer
  function automatic answer_t arbitrate_request(logic [ReqW-1:0] req,
                                                logic [SrcW-1:0] src);
    answer_t         ans;
    logic [SlotBits-1:0] best;
    logic            known;
    ans   = '0;
    known = (src != 0) && (src < NumSrc);
    case (req)
      REQ_RAISE: begin
        if (known && !mdl_in_service[src]) mdl_pending[src] = 1'b1;
      end
      REQ_CLAIM: begin
        best = mdl_threshold;
        for (int n = 1; n < NumSrc; n++) begin
          if (mdl_pending[n] && mdl_enable[n] && source_priority(n) > best) begin
            best           = source_priority(n);
            ans.claimed_id = SrcW'(n);
          end
        end
        if (ans.claimed_id != NoGrant) begin
          mdl_pending[ans.claimed_id]    = 1'b0;
          mdl_in_service[ans.claimed_id] = 1'b1;
        end
      end
      REQ_COMPLETE: begin
        if (known && mdl_enable[src]) mdl_in_service[src] = 1'b0;
      end
      REQ_QUERY: begin
        if (known) ans.is_pending = mdl_pending[src];
      end
      default: ;
    endcase
    return ans;
  endfunction

  // script row builders
  function automatic script_row_t row_word(logic [ReqW-1:0] req, logic [SrcW-1:0] src);
    script_row_t r;
    r.is_cfg   = 1'b0;
    r.req      = req;
    r.src      = src;
    r.reg_idx  = CFG_THRESHOLD;
    r.reg_data = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic script_row_t row_typed(logic [ReqW-1:0] req, logic [SrcW-1:0] src,
                                            logic [SrcW-1:0] id, logic pend);
    script_row_t r;
    r       = row_word(req, src);
    r.typed = 1'b1;
    r.want  = '{claimed_id: id, is_pending: pend};
    return r;
  endfunction

  function automatic script_row_t row_cfg(logic [CfgIdxW-1:0] idx,
                                          logic [CfgDataW-1:0] data);
    script_row_t r;
    r          = row_word(REQ_RAISE, '0);
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_data();
    return CfgDataW'({$urandom(), $urandom()});
  endfunction

  // register write, called at a falling edge while the block is idle
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_THRESHOLD: mdl_threshold = data[ThreshW-1:0];
      CFG_ENABLE:    mdl_enable    = data[EnableW-1:0];
      CFG_PRIO_LOW:  mdl_prio_lo   = data[PrioRegW-1:0];
      CFG_PRIO_HIGH: mdl_prio_hi   = data[PrioRegW-1:0];
      default: ;
    endcase
  endtask

  // offer one request word; valid is left high for the caller to reuse or drop
  task automatic send_request(logic [ReqW-1:0] req, logic [SrcW-1:0] src,
                              bit typed, answer_t typed_ans);
    answer_t ans;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    req_type_i  = req;
    source_id_i = src;
    do @(posedge clk_i); while (!in_ready_o);
    ans = arbitrate_request(req, src);
    answers_due.push_back(typed ? typed_ans : ans);
    n_words++;
    if (req == REQ_CLAIM) begin
      if (ans.claimed_id != NoGrant) n_grants++;
      else n_empty_claim++;
    end
    @(negedge clk_i);
  endtask

  // drop valid and wait until every answer is back and a claim scan would be over
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected word, claimed_id", 0, claimed_id_o);
      end else begin
        want_now = answers_due.pop_front();
        n_checked++;
        if (claimed_id_o !== want_now.claimed_id)
          report_mismatch("claimed_id", want_now.claimed_id, claimed_id_o);
        if (is_pending_o !== want_now.is_pending)
          report_mismatch("is_pending", want_now.is_pending, is_pending_o);
      end
    end
  end

  // result side backpressure, with an optional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      rx_pct_now = rx_stall_pct;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_pct_now);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("%0t: timeout with %0d words outstanding", $time, answers_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [ReqW-1:0]     req;
    logic [SrcW-1:0]     src;
    logic [CfgDataW-1:0] data;
    int unsigned         roll;

    mdl_threshold  = '0;
    mdl_enable     = '0;
    mdl_prio_lo    = '0;
    mdl_prio_hi    = '0;
    mdl_pending    = '0;
    mdl_in_service = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed script
    script.push_back(row_typed(REQ_CLAIM, 5'd0, NoGrant, 1'b0));   // nothing after reset
    script.push_back(row_typed(REQ_QUERY, 5'd0, NoGrant, 1'b0));
    script.push_back(row_word(REQ_RAISE, 5'd0));                    // source zero is dead
    script.push_back(row_typed(REQ_QUERY, 5'd0, NoGrant, 1'b0));
    script.push_back(row_word(REQ_RAISE, 5'd5));
    script.push_back(row_word(REQ_RAISE, 5'd5));                    // raise while pending
    script.push_back(row_typed(REQ_QUERY, 5'd5, NoGrant, 1'b1));
    script.push_back(row_cfg(CFG_ENABLE, '1));                      // upper bits dropped
    script.push_back(row_cfg(CFG_PRIO_LOW, '1));
    script.push_back(row_cfg(CFG_PRIO_HIGH, '1));
    script.push_back(row_cfg(CFG_THRESHOLD, 48'h7));
    script.push_back(row_typed(REQ_CLAIM, 5'd31, NoGrant, 1'b0));  // all masked at top threshold
    script.push_back(row_cfg(CFG_THRESHOLD, 48'hFFFF_FFFF_FFF8));   // lands as zero
    script.push_back(row_word(REQ_RAISE, 5'd31));
    script.push_back(row_word(REQ_RAISE, 5'd1));
    script.push_back(row_word(REQ_CLAIM, 5'd17));                   // tie, lowest id wins
    script.push_back(row_word(REQ_RAISE, 5'd1));                    // raise while in service
    script.push_back(row_word(REQ_QUERY, 5'd1));
    script.push_back(row_word(REQ_COMPLETE, 5'd0));
    script.push_back(row_word(REQ_COMPLETE, 5'd3));                 // not in service
    script.push_back(row_cfg(CFG_ENABLE, '0));
    script.push_back(row_word(REQ_COMPLETE, 5'd1));                 // disabled, stays in service
    script.push_back(row_word(REQ_RAISE, 5'd1));
    script.push_back(row_cfg(CFG_ENABLE, 48'h0000_FFFF_FFFF));
    script.push_back(row_word(REQ_COMPLETE, 5'd1));
    script.push_back(row_word(REQ_RAISE, 5'd1));
    script.push_back(row_cfg(CFG_PRIO_LOW, '0));                    // priority zero never wins
    script.push_back(row_word(REQ_CLAIM, 5'd0));
    script.push_back(row_word(REQ_CLAIM, 5'd31));
    script.push_back(row_word(REQ_COMPLETE, 5'd31));
    script.push_back(row_word(REQ_QUERY, 5'd31));
    script.push_back(row_word(REQ_QUERY, 5'd1));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_idle();
        write_register(script[i].reg_idx, script[i].reg_data);
      end else begin
        send_request(script[i].req, script[i].src, script[i].typed, script[i].want);
      end
    end
    wait_idle();

    // random phases with different flow control and register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      data = rand_data();
      case (ph)
        0: begin
          write_register(CFG_THRESHOLD, {data[CfgDataW-1:ThreshW], 3'd0});
          write_register(CFG_ENABLE, '1);
          write_register(CFG_PRIO_LOW, rand_data());
          write_register(CFG_PRIO_HIGH, rand_data());
        end
        1: begin
          write_register(CFG_THRESHOLD, {data[CfgDataW-1:ThreshW], 3'($urandom_range(3))});
          write_register(CFG_ENABLE, rand_data());
          write_register(CFG_PRIO_LOW, rand_data());
          write_register(CFG_PRIO_HIGH, rand_data());
        end
        2: begin
          write_register(CFG_THRESHOLD, {data[CfgDataW-1:ThreshW], 3'd1});
          write_register(CFG_ENABLE, rand_data() | 48'h0000_FFF0_FFF0);
          write_register(CFG_PRIO_LOW, rand_data());
          write_register(CFG_PRIO_HIGH, '1);
        end
        default: begin
          write_register(CFG_THRESHOLD, {data[CfgDataW-1:ThreshW], 3'($urandom_range(2))});
          write_register(CFG_ENABLE, '1);
          write_register(CFG_PRIO_LOW, '0);
          write_register(CFG_PRIO_HIGH, rand_data());
        end
      endcase

      // long result stall while requests keep coming, so the input backs up
      if (ph == 0) hold_request = HoldOffCycles;

      for (int unsigned w = 0; w < WordsPerPhase; w++) begin
        roll = $urandom_range(99);
        src  = SrcW'($urandom_range(NumSrc - 1));
        if (roll < 40) begin
          req = REQ_RAISE;
        end else if (roll < 65) begin
          req = REQ_CLAIM;
        end else if (roll < 85) begin
          req = REQ_COMPLETE;
          // mostly finish a source that is really in service
          if (mdl_in_service != '0 && $urandom_range(9) < 7) begin
            do src = SrcW'($urandom_range(NumSrc - 1, 1)); while (!mdl_in_service[src]);
          end
        end else begin
          req = REQ_QUERY;
        end
        send_request(req, src, 1'b0, '0);
      end
      wait_idle();
    end

    $display("covered %0d request words, %0d results checked", n_words, n_checked);
    $display("claims granted %0d, claims with no candidate %0d, %0d mismatches",
             n_grants, n_empty_claim, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/picc_pkg.sv
hdl/picc_arb.sv
hdl/interrupt_claim_complete_controller_top.sv
verif/interrupt_claim_complete_controller_top_tb.sv
